// File: hw/rtl/tfv_pkg.sv
// Shared types and codes for the TLV frame validator.
// No dependencies.
package tfv_pkg;

  typedef enum logic [2:0] {
    STATUS_ACCEPT     = 3'd0,
    STATUS_COMPAT     = 3'd1,
    STATUS_BAD_MAGIC  = 3'd2,
    STATUS_BAD_LENCMD = 3'd3,
    STATUS_BAD_STRUCT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_MAGIC_FIRST   = 3'd0,
    REG_MAGIC_SECOND  = 3'd1,
    REG_CMD_PROPERTY  = 3'd2,
    REG_CMD_FACTORY   = 3'd3,
    REG_CMD_BOOTSTRAP = 3'd4,
    REG_CMD_COMPAT    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] cmd_property;
    logic [7:0] cmd_factory;
    logic [7:0] cmd_bootstrap;
    logic [7:0] cmd_compat;
  } cfg_t;

  typedef struct packed {
    logic [8:0] rx_length;
    logic [7:0] command_code;
    status_t    status;
  } result_t;

  localparam int unsigned MIN_FRAME = 8;

endpackage

// File: hw/rtl/tfv_parser.sv
// Input register, per-frame parse state and end-of-frame verdict.
// Depends on tfv_pkg.
module tfv_parser #(
  parameter int unsigned FRAME_MAX = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  tfv_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             out_space,
  output logic             res_push,
  output tfv_pkg::result_t res
);

  localparam int unsigned CNT_W = $clog2(FRAME_MAX + 1);
  localparam logic [CNT_W-1:0] FRAME_MAX_C = CNT_W'(FRAME_MAX);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             consume;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      len_field, len_field_next;
  logic [7:0]       command_seen, command_seen_next;
  logic             header_error, header_error_next;
  phase_t           seg_phase, seg_phase_next;
  logic [15:0]      seg_remaining, seg_remaining_next;
  phase_t           fld_phase, fld_phase_next;
  logic [15:0]      fld_remaining, fld_remaining_next;
  logic [7:0]       len_hold, len_hold_next;
  logic             structure_error, structure_error_next;
  logic             overflow, overflow_next;

  logic [31:0]      count_ext;
  logic [15:0]      expected_length;
  logic             cmd_known;

  assign consume  = s1_valid && (!s1_last || out_space);
  assign in_ready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= in_data;
      s1_last <= in_last;
    end
  end

  always_comb begin
    phase_t      fph;
    logic [15:0] frem;
    logic [7:0]  fhold;
    byte_count_next      = byte_count;
    len_field_next       = len_field;
    command_seen_next    = command_seen;
    header_error_next    = header_error;
    seg_phase_next       = seg_phase;
    seg_remaining_next   = seg_remaining;
    fld_phase_next       = fld_phase;
    fld_remaining_next   = fld_remaining;
    len_hold_next        = len_hold;
    structure_error_next = structure_error;
    overflow_next        = overflow;
    fph   = fld_phase;
    frem  = fld_remaining;
    fhold = len_hold;

    unique case (fld_phase)
      PH_TYPE: begin
        fph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        fhold = s1_byte;
        fph   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frem = {len_hold, s1_byte};
        fph  = (frem != 16'd0) ? PH_BODY : PH_TYPE;
      end
      PH_BODY: begin
        frem = fld_remaining - 16'd1;
        if (frem == 16'd0) begin
          fph = PH_TYPE;
        end
      end
      default: ;
    endcase

    if (byte_count < FRAME_MAX_C) begin
      byte_count_next = byte_count + CNT_W'(1);
      priority if (byte_count == CNT_W'(0)) begin
        if (s1_byte != cfg.magic_first) header_error_next = 1'b1;
      end else if (byte_count == CNT_W'(1)) begin
        if (s1_byte != cfg.magic_second) header_error_next = 1'b1;
      end else if (byte_count == CNT_W'(2)) begin
        len_field_next = {s1_byte, 8'd0};
      end else if (byte_count == CNT_W'(3)) begin
        len_field_next = {len_field[15:8], s1_byte};
      end else if (byte_count == CNT_W'(4)) begin
        command_seen_next = s1_byte;
      end else begin
        unique case (seg_phase)
          PH_TYPE: begin
            seg_phase_next = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_hold_next  = s1_byte;
            seg_phase_next = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            seg_remaining_next = {len_hold, s1_byte};
            fld_phase_next     = PH_TYPE;
            fld_remaining_next = 16'd0;
            seg_phase_next     = ({len_hold, s1_byte} != 16'd0) ? PH_BODY : PH_TYPE;
          end
          PH_BODY: begin
            fld_phase_next     = fph;
            fld_remaining_next = frem;
            len_hold_next      = fhold;
            seg_remaining_next = seg_remaining - 16'd1;
            if (seg_remaining == 16'd1) begin
              if (fph != PH_TYPE) structure_error_next = 1'b1;
              fld_phase_next     = PH_TYPE;
              fld_remaining_next = 16'd0;
              seg_phase_next     = PH_TYPE;
            end
          end
          default: ;
        endcase
      end
    end else begin
      overflow_next = 1'b1;
    end
  end

  assign count_ext       = 32'(byte_count_next);
  assign expected_length = 16'(count_ext - 32'd4);
  assign cmd_known = (command_seen_next == cfg.cmd_property) ||
                     (command_seen_next == cfg.cmd_factory) ||
                     (command_seen_next == cfg.cmd_bootstrap) ||
                     (command_seen_next == cfg.cmd_compat);

  always_ff @(posedge clk) begin
    if (rst || (consume && s1_last)) begin
      byte_count      <= '0;
      len_field       <= '0;
      command_seen    <= '0;
      header_error    <= 1'b0;
      seg_phase       <= PH_TYPE;
      seg_remaining   <= '0;
      fld_phase       <= PH_TYPE;
      fld_remaining   <= '0;
      len_hold        <= '0;
      structure_error <= 1'b0;
      overflow        <= 1'b0;
    end else if (consume) begin
      byte_count      <= byte_count_next;
      len_field       <= len_field_next;
      command_seen    <= command_seen_next;
      header_error    <= header_error_next;
      seg_phase       <= seg_phase_next;
      seg_remaining   <= seg_remaining_next;
      fld_phase       <= fld_phase_next;
      fld_remaining   <= fld_remaining_next;
      len_hold        <= len_hold_next;
      structure_error <= structure_error_next;
      overflow        <= overflow_next;
    end
  end

  assign res_push = consume && s1_last;

  always_comb begin
    res.command_code = command_seen_next;
    res.rx_length    = count_ext[8:0];
    priority if (header_error_next) begin
      res.status = tfv_pkg::STATUS_BAD_MAGIC;
    end else if (overflow_next || (count_ext < 32'(tfv_pkg::MIN_FRAME)) ||
                 (len_field_next != expected_length) || !cmd_known) begin
      res.status = tfv_pkg::STATUS_BAD_LENCMD;
    end else if (command_seen_next == cfg.cmd_compat) begin
      res.status = tfv_pkg::STATUS_COMPAT;
    end else if (structure_error_next || (seg_phase_next != PH_TYPE)) begin
      res.status = tfv_pkg::STATUS_BAD_STRUCT;
    end else begin
      res.status = tfv_pkg::STATUS_ACCEPT;
    end
  end

endmodule

// File: hw/rtl/tfv_result_fifo.sv
// Two-entry result queue; decouples verdicts from the output stream.
// Depends on tfv_pkg.
module tfv_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tfv_pkg::result_t push_data,
  output logic             space,
  output logic             m_valid,
  input  logic             m_ready,
  output tfv_pkg::result_t m_data
);

  tfv_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = (count != 2'd0);
  assign space   = (count != 2'd2);
  assign m_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hw/rtl/tlv_frame_validator.sv
// Top level of the TLV frame validator: configuration registers, parser, result queue.
// Depends on tfv_pkg, tfv_parser and tfv_result_fifo.
//
//  channel  | direction | content
//  s_*      | in        | one frame byte per request, tlast on the final byte
//  m_*      | out       | one verdict per frame
//  cfg_*    | in        | register write, indexes 0..5
//
// One byte per cycle sustained until a last byte meets a full result queue; a verdict passes
// through the input register, then the result queue. The result queue holds two verdicts; when
// it is full a last byte waits in the input register. Reset clears frame state
// and loads the register defaults.
module tlv_frame_validator #(
  parameter int unsigned FRAME_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[2:0], command_code[10:3], rx_length[19:11], zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tfv_pkg::cfg_t    cfg;
  tfv_pkg::result_t res;
  tfv_pkg::result_t out_res;
  logic             res_push;
  logic             out_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first   <= 8'd170;
      cfg.magic_second  <= 8'd85;
      cfg.cmd_property  <= 8'd1;
      cfg.cmd_factory   <= 8'd2;
      cfg.cmd_bootstrap <= 8'd3;
      cfg.cmd_compat    <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfv_pkg::REG_MAGIC_FIRST:   cfg.magic_first   <= cfg_data;
        tfv_pkg::REG_MAGIC_SECOND:  cfg.magic_second  <= cfg_data;
        tfv_pkg::REG_CMD_PROPERTY:  cfg.cmd_property  <= cfg_data;
        tfv_pkg::REG_CMD_FACTORY:   cfg.cmd_factory   <= cfg_data;
        tfv_pkg::REG_CMD_BOOTSTRAP: cfg.cmd_bootstrap <= cfg_data;
        tfv_pkg::REG_CMD_COMPAT:    cfg.cmd_compat    <= cfg_data;
        default: ;
      endcase
    end
  end

  tfv_parser #(
    .FRAME_MAX(FRAME_MAX)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .out_space(out_space),
    .res_push (res_push),
    .res      (res)
  );

  tfv_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .space    (out_space),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_data   (out_res)
  );

  assign m_tdata = {4'd0, out_res.rx_length, out_res.command_code, out_res.status};

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    res_push |=> m_tvalid)
    else $error("verdict pushed but output not valid");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> out_space)
    else $error("verdict pushed into full queue");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'd4))
    else $error("status code out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

endmodule
